/* sv/tbpr_pkg.sv */
// shared types, constants and helpers for the tile background pixel renderer
package tbpr_pkg;

   localparam int VRAM_BYTES    = 8192;
   localparam int VRAM_AW       = $clog2(VRAM_BYTES);
   localparam int VRAM_WORDS    = VRAM_BYTES / 2;
   localparam int VRAM_WAW      = VRAM_AW - 1;
   localparam int SCREEN_WIDTH  = 160;
   localparam int SCREEN_HEIGHT = 144;

   localparam logic [VRAM_AW-1:0] MAP_LOW_OFFSET     = VRAM_AW'(16'h1800);
   localparam logic [VRAM_AW-1:0] MAP_HIGH_OFFSET    = VRAM_AW'(16'h1C00);
   localparam logic [VRAM_AW-1:0] SIGNED_DATA_OFFSET = VRAM_AW'(16'h0800);
   localparam logic [7:0]         WINDOW_X_BIAS      = 8'd7;
   localparam logic [7:0]         SIGNED_BIAS        = 8'h80;

   typedef enum logic {
      FUNC_WRITE  = 1'b0,
      FUNC_RENDER = 1'b1
   } func_type;

   typedef enum logic [2:0] {
      CSR_SCROLL_X           = 3'd0,
      CSR_SCROLL_Y           = 3'd1,
      CSR_WINDOW_X_RAW       = 3'd2,
      CSR_WINDOW_Y           = 3'd3,
      CSR_BG_ENABLE          = 3'd4,
      CSR_WINDOW_ENABLE      = 3'd5,
      CSR_TILE_DATA_UNSIGNED = 3'd6,
      CSR_MAP_HIGH           = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [7:0] scroll_x;
      logic [7:0] scroll_y;
      logic [7:0] window_x_raw;
      logic [7:0] window_y;
      logic       bg_enable;
      logic       window_enable;
      logic       tile_data_unsigned;
      logic       map_high;
   } cfg_type;

   // one item as it travels down the pipeline
   typedef struct packed {
      logic               is_write;
      logic               has_result;
      logic [7:0]         xp;
      logic [7:0]         yp;
      logic [7:0]         column;
      logic [7:0]         row;
      logic [VRAM_AW-1:0] vram_offset;
      logic [7:0]         vram_byte;
   } item_type;

   function automatic logic [7:0] grey_level(input logic [1:0] idx);
      logic [7:0] g;
      case (idx)
         2'd0:    g = 8'hFF;
         2'd1:    g = 8'hA2;
         2'd2:    g = 8'h4E;
         default: g = 8'h00;
      endcase
      return g;
   endfunction

endpackage

/* sv/tbpr_if.sv */
// handshake channels: request, response and register write
interface tbpr_req_if;
   logic                         valid;
   logic                         ready;
   logic                         func;
   logic [tbpr_pkg::VRAM_AW-1:0] vram_offset;
   logic [7:0]                   vram_byte;
   logic [7:0]                   column;
   logic [7:0]                   row;
   modport source (output valid, func, vram_offset, vram_byte, column, row, input ready);
   modport sink (input valid, func, vram_offset, vram_byte, column, row, output ready);
endinterface

interface tbpr_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_column;
   logic [7:0] out_row;
   logic [1:0] color_index;
   logic [7:0] shade;
   modport source (output valid, out_column, out_row, color_index, shade, input ready);
   modport sink (input valid, out_column, out_row, color_index, shade, output ready);
endinterface

interface tbpr_csr_if;
   logic       valid;
   logic       ready;
   logic [2:0] index;
   logic [7:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

/* sv/tile_background_pixel_render_top.sv */
// top level: four-stage pixel pipeline around the video memory
// a render beat passes the stage 1, 2, 3 and 4 registers in order and shows on rsp from stage 4
// throughput: one beat per cycle while rsp takes its beats, writes and renders freely mixed
// the pipeline advances as a whole; it freezes only while rsp holds a beat not taken
// the two dependent reads (tile map, then both bit planes) use the two memory read ports
// reset clears valid bits and the configuration registers; video memory keeps its contents
module tile_background_pixel_render_top #(
   parameter int SCREEN_WIDTH = tbpr_pkg::SCREEN_WIDTH
) (
   input  logic       clock,
   input  logic       reset,
   tbpr_req_if.sink   req_bus,
   tbpr_rsp_if.source rsp_bus,
   tbpr_csr_if.sink   csr_bus
);

   localparam int AW = tbpr_pkg::VRAM_AW;
   localparam logic [8:0] WIDTH_LIM  = 9'(SCREEN_WIDTH);
   localparam logic [8:0] HEIGHT_LIM = 9'(tbpr_pkg::SCREEN_HEIGHT);

   tbpr_pkg::cfg_type  cfg;
   tbpr_pkg::item_type item0;

   logic adv;

   logic               s1_valid_ff, s1_valid_in;
   tbpr_pkg::item_type s1_item_ff, s1_item_in;
   logic               s2_valid_ff, s2_valid_in;
   tbpr_pkg::item_type s2_item_ff, s2_item_in;
   logic               s2_lsb_ff, s2_lsb_in;
   logic               s2_fwd_ff, s2_fwd_in;
   logic [7:0]         s2_fwd_byte_ff, s2_fwd_byte_in;
   logic               s3_valid_ff, s3_valid_in;
   tbpr_pkg::item_type s3_item_ff, s3_item_in;
   logic               s4_valid_ff, s4_valid_in;
   logic [7:0]         s4_column_ff, s4_column_in;
   logic [7:0]         s4_row_ff, s4_row_in;
   logic [1:0]         s4_idx_ff, s4_idx_in;
   logic [7:0]         s4_shade_ff, s4_shade_in;

   logic [AW-1:0] map_addr;
   logic          fwd_hit;
   logic [7:0]    tile;
   logic [7:0]    tile_sel;
   logic [AW-1:0] data_base;
   logic [AW-1:0] data_addr;
   logic [15:0]   map_word;
   logic [15:0]   plane_word;
   logic [2:0]    bit_sel;
   logic [1:0]    pix_idx;
   logic          rd_a_en;
   logic          rd_b_en;
   logic          wr_en;

   tbpr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   tbpr_coord #(
      .SCREEN_WIDTH (SCREEN_WIDTH)
   ) u_coord (
      .func        (req_bus.func),
      .vram_offset (req_bus.vram_offset),
      .vram_byte   (req_bus.vram_byte),
      .column      (req_bus.column),
      .row         (req_bus.row),
      .cfg         (cfg),
      .item        (item0)
   );

   assign adv           = !s4_valid_ff || rsp_bus.ready;
   assign req_bus.ready = adv;

   // stage 1: tile map read; a write one stage ahead to the same byte is forwarded
   always_comb begin
      map_addr = (cfg.map_high ? tbpr_pkg::MAP_HIGH_OFFSET : tbpr_pkg::MAP_LOW_OFFSET)
               + AW'({s1_item_ff.yp[7:3], s1_item_ff.xp[7:3]});
      fwd_hit  = s2_valid_ff && s2_item_ff.is_write && (s2_item_ff.vram_offset == map_addr);
      rd_a_en  = adv && s1_valid_ff && s1_item_ff.has_result;
   end

   // stage 2: tile data address, plane read, or the memory write
   always_comb begin
      tile     = s2_fwd_ff ? s2_fwd_byte_ff : (s2_lsb_ff ? map_word[15:8] : map_word[7:0]);
      tile_sel = cfg.tile_data_unsigned ? tile : (tile ^ tbpr_pkg::SIGNED_BIAS);
      data_base = cfg.tile_data_unsigned ? '0 : tbpr_pkg::SIGNED_DATA_OFFSET;
      data_addr = data_base + AW'({tile_sel, s2_item_ff.yp[2:0], 1'b0});
      rd_b_en  = adv && s2_valid_ff && s2_item_ff.has_result;
      wr_en    = adv && s2_valid_ff && s2_item_ff.is_write;
   end

   tbpr_vram u_vram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (s2_item_ff.vram_offset),
      .wr_data   (s2_item_ff.vram_byte),
      .rd_a_en   (rd_a_en),
      .rd_a_addr (map_addr[AW-1:1]),
      .rd_a_data (map_word),
      .rd_b_en   (rd_b_en),
      .rd_b_addr (data_addr[AW-1:1]),
      .rd_b_data (plane_word)
   );

   // stage 3: pick the pixel bit from both planes, low plane gives bit 0
   always_comb begin
      bit_sel = ~s3_item_ff.xp[2:0];
      pix_idx = cfg.bg_enable ? {plane_word[8 + bit_sel], plane_word[bit_sel]} : 2'd0;
   end

   always_comb begin
      s1_valid_in    = req_bus.valid;
      s1_item_in     = item0;
      s2_valid_in    = s1_valid_ff;
      s2_item_in     = s1_item_ff;
      s2_lsb_in      = map_addr[0];
      s2_fwd_in      = fwd_hit;
      s2_fwd_byte_in = s2_item_ff.vram_byte;
      s3_valid_in    = s2_valid_ff;
      s3_item_in     = s2_item_ff;
      s4_valid_in    = s3_valid_ff && s3_item_ff.has_result;
      s4_column_in   = s3_item_ff.column;
      s4_row_in      = s3_item_ff.row;
      s4_idx_in      = pix_idx;
      s4_shade_in    = tbpr_pkg::grey_level(pix_idx);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
         s4_valid_ff <= s4_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_item_ff     <= s1_item_in;
         s2_item_ff     <= s2_item_in;
         s2_lsb_ff      <= s2_lsb_in;
         s2_fwd_ff      <= s2_fwd_in;
         s2_fwd_byte_ff <= s2_fwd_byte_in;
         s3_item_ff     <= s3_item_in;
         s4_column_ff   <= s4_column_in;
         s4_row_ff      <= s4_row_in;
         s4_idx_ff      <= s4_idx_in;
         s4_shade_ff    <= s4_shade_in;
      end
   end

   assign rsp_bus.valid       = s4_valid_ff;
   assign rsp_bus.out_column  = s4_column_ff;
   assign rsp_bus.out_row     = s4_row_ff;
   assign rsp_bus.color_index = s4_idx_ff;
   assign rsp_bus.shade       = s4_shade_ff;

   a_rsp_on_screen: assert property (@(posedge clock) disable iff (reset)
      s4_valid_ff |-> ({1'b0, s4_row_ff} < HEIGHT_LIM) && ({1'b0, s4_column_ff} < WIDTH_LIM))
      else $error("pixel beat outside the screen");

   a_bg_off_white: assert property (@(posedge clock) disable iff (reset)
      s4_valid_ff && !cfg.bg_enable |-> (s4_idx_ff == 2'd0) && (s4_shade_ff == 8'hFF))
      else $error("background disabled but pixel not white");

   a_fwd_capture: assert property (@(posedge clock) disable iff (reset)
      adv && s1_valid_ff && s1_item_ff.has_result && fwd_hit |=> s2_fwd_ff)
      else $error("write to tile map entry not forwarded");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(s1_valid_ff) && $stable(s2_valid_ff) && $stable(s3_valid_ff))
      else $error("pipeline moved during stall");

   a_write_vs_read: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff && s2_item_ff.is_write |-> !rd_b_en && !(s2_valid_ff && s2_item_ff.has_result))
      else $error("write beat also issued a plane read");

endmodule

/* sv/tbpr_csr.sv */
// configuration register file
module tbpr_csr (
   input  logic              clock,
   input  logic              reset,
   tbpr_csr_if.sink          csr_bus,
   output tbpr_pkg::cfg_type cfg
);

   tbpr_pkg::cfg_type cfg_ff;
   tbpr_pkg::cfg_type cfg_in;

   assign csr_bus.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         unique case (tbpr_pkg::csr_index_type'(csr_bus.index))
            tbpr_pkg::CSR_SCROLL_X:           cfg_in.scroll_x           = csr_bus.data;
            tbpr_pkg::CSR_SCROLL_Y:           cfg_in.scroll_y           = csr_bus.data;
            tbpr_pkg::CSR_WINDOW_X_RAW:       cfg_in.window_x_raw       = csr_bus.data;
            tbpr_pkg::CSR_WINDOW_Y:           cfg_in.window_y           = csr_bus.data;
            tbpr_pkg::CSR_BG_ENABLE:          cfg_in.bg_enable          = csr_bus.data[0];
            tbpr_pkg::CSR_WINDOW_ENABLE:      cfg_in.window_enable      = csr_bus.data[0];
            tbpr_pkg::CSR_TILE_DATA_UNSIGNED: cfg_in.tile_data_unsigned = csr_bus.data[0];
            tbpr_pkg::CSR_MAP_HIGH:           cfg_in.map_high           = csr_bus.data[0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* sv/tbpr_coord.sv */
// front stage: classify the beat and map screen position to background or window space
module tbpr_coord #(
   parameter int SCREEN_WIDTH = tbpr_pkg::SCREEN_WIDTH
) (
   input  logic                         func,
   input  logic [tbpr_pkg::VRAM_AW-1:0] vram_offset,
   input  logic [7:0]                   vram_byte,
   input  logic [7:0]                   column,
   input  logic [7:0]                   row,
   input  tbpr_pkg::cfg_type            cfg,
   output tbpr_pkg::item_type           item
);

   localparam logic [8:0] WIDTH_LIM  = 9'(SCREEN_WIDTH);
   localparam logic [8:0] HEIGHT_LIM = 9'(tbpr_pkg::SCREEN_HEIGHT);

   logic [7:0] left;
   logic       in_window;
   logic       on_screen;
   logic       is_write;

   always_comb begin
      // window left edge, clamped at zero
      left = (cfg.window_x_raw >= tbpr_pkg::WINDOW_X_BIAS) ?
             cfg.window_x_raw - tbpr_pkg::WINDOW_X_BIAS : 8'd0;
      in_window = cfg.window_enable && (row >= cfg.window_y) && (column >= left);
      on_screen = ({1'b0, column} < WIDTH_LIM) && ({1'b0, row} < HEIGHT_LIM);
      is_write  = (tbpr_pkg::func_type'(func) == tbpr_pkg::FUNC_WRITE);

      item.is_write    = is_write;
      item.has_result  = !is_write && on_screen;
      item.xp          = in_window ? column - left : column + cfg.scroll_x;
      item.yp          = in_window ? row - cfg.window_y : row + cfg.scroll_y;
      item.column      = column;
      item.row         = row;
      item.vram_offset = vram_offset;
      item.vram_byte   = vram_byte;
   end

endmodule

/* sv/tbpr_vram.sv */
// video memory: 16-bit words with byte write lanes, two registered read ports
module tbpr_vram (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [tbpr_pkg::VRAM_AW-1:0]  wr_addr,
   input  logic [7:0]                    wr_data,
   input  logic                          rd_a_en,
   input  logic [tbpr_pkg::VRAM_WAW-1:0] rd_a_addr,
   output logic [15:0]                   rd_a_data,
   input  logic                          rd_b_en,
   input  logic [tbpr_pkg::VRAM_WAW-1:0] rd_b_addr,
   output logic [15:0]                   rd_b_data
);

   logic [15:0] mem_ff [tbpr_pkg::VRAM_WORDS];
   logic [15:0] rd_a_data_ff;
   logic [15:0] rd_b_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         if (wr_addr[0]) begin
            mem_ff[wr_addr[tbpr_pkg::VRAM_AW-1:1]][15:8] <= wr_data;
         end else begin
            mem_ff[wr_addr[tbpr_pkg::VRAM_AW-1:1]][7:0] <= wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rd_a_en) begin
         rd_a_data_ff <= mem_ff[rd_a_addr];
      end
      if (rd_b_en) begin
         rd_b_data_ff <= mem_ff[rd_b_addr];
      end
   end

   assign rd_a_data = rd_a_data_ff;
   assign rd_b_data = rd_b_data_ff;

endmodule

/* dv/tile_background_pixel_render_top_tb.sv */
// self-checking bench for the tile background renderer: mirrors video memory and registers
`timescale 1ns / 1ps

module tile_background_pixel_render_top_tb;
   import tbpr_pkg::*;

   localparam int DRAIN_CYCLES  = 8;
   localparam int STALL_LIMIT   = 3000;
   localparam int RANDOM_BEATS  = 1100;
   localparam int PHASE_BEATS   = 110;
   localparam int HOLD_CYCLES   = 300;

   typedef struct packed {
      logic [7:0] column;
      logic [7:0] row;
      logic [1:0] color_index;
      logic [7:0] shade;
   } pixel_type;

   logic clock = 1'b0;
   logic reset;

   tbpr_req_if req_bus ();
   tbpr_rsp_if rsp_bus ();
   tbpr_csr_if csr_bus ();

   tile_background_pixel_render_top u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always #2 clock = ~clock;

   logic [7:0] vram_mirror [VRAM_BYTES];
   bit         vram_loaded [VRAM_BYTES];
   cfg_type    cfg_mirror = '0;
   pixel_type  pending_pixels [$];

   bit steady_flow  = 1'b0;
   int hold_request = 0;
   int error_count  = 0;
   int beats_sent   = 0;
   int writes_sent  = 0;
   int renders_sent = 0;
   int pixels_checked   = 0;
   int settings_applied = 0;

   task automatic report_error(input string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      error_count++;
   endtask

   // ---------------------------------------------------------------- prediction

   function automatic void pixel_space(input logic [7:0] col, input logic [7:0] row,
                                       output logic [7:0] xp, output logic [7:0] yp);
      logic [7:0] left;
      left = (cfg_mirror.window_x_raw >= WINDOW_X_BIAS) ?
             cfg_mirror.window_x_raw - WINDOW_X_BIAS : 8'd0;
      if (cfg_mirror.window_enable && row >= cfg_mirror.window_y && col >= left) begin
         xp = col - left;
         yp = row - cfg_mirror.window_y;
      end else begin
         xp = col + cfg_mirror.scroll_x;
         yp = row + cfg_mirror.scroll_y;
      end
   endfunction

   function automatic logic [VRAM_AW-1:0] map_address(input logic [7:0] xp,
                                                      input logic [7:0] yp);
      return (cfg_mirror.map_high ? MAP_HIGH_OFFSET : MAP_LOW_OFFSET) +
             VRAM_AW'({yp[7:3], xp[7:3]});
   endfunction

   // low plane byte of the tile line; the high plane follows it
   function automatic logic [VRAM_AW-1:0] plane_address(input logic [7:0] tile,
                                                        input logic [7:0] yp);
      if (cfg_mirror.tile_data_unsigned)
         return VRAM_AW'({tile, yp[2:0], 1'b0});
      return SIGNED_DATA_OFFSET + VRAM_AW'({tile ^ SIGNED_BIAS, yp[2:0], 1'b0});
   endfunction

   function automatic pixel_type predict_pixel(input logic [7:0] col, input logic [7:0] row);
      pixel_type          p;
      logic [7:0]         xp;
      logic [7:0]         yp;
      logic [7:0]         lo;
      logic [7:0]         hi;
      logic [VRAM_AW-1:0] plane_a;
      logic [2:0]         bit_pos;
      p.column      = col;
      p.row         = row;
      p.color_index = 2'd0;
      if (cfg_mirror.bg_enable) begin
         pixel_space(col, row, xp, yp);
         plane_a = plane_address(vram_mirror[map_address(xp, yp)], yp);
         lo      = vram_mirror[plane_a];
         hi      = vram_mirror[plane_a + 1'b1];
         bit_pos = 3'd7 - xp[2:0];
         p.color_index = {hi[bit_pos], lo[bit_pos]};
      end
      case (p.color_index)
         2'd0:    p.shade = 8'hFF;
         2'd1:    p.shade = 8'hA2;
         2'd2:    p.shade = 8'h4E;
         default: p.shade = 8'h00;
      endcase
      return p;
   endfunction

   // ---------------------------------------------------------------- drivers

   task automatic send_beat(input func_type f, input logic [VRAM_AW-1:0] offset,
                            input logic [7:0] data, input logic [7:0] col,
                            input logic [7:0] row);
      @(negedge clock);
      while (!steady_flow && $urandom_range(99) < 36) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.func        <= f;
      req_bus.vram_offset <= offset;
      req_bus.vram_byte   <= data;
      req_bus.column      <= col;
      req_bus.row         <= row;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      beats_sent++;
      if (f == FUNC_WRITE) begin
         writes_sent++;
         vram_mirror[offset] = data;
         vram_loaded[offset] = 1'b1;
      end else begin
         renders_sent++;
         if (col < SCREEN_WIDTH && row < SCREEN_HEIGHT)
            pending_pixels.push_back(predict_pixel(col, row));
      end
   endtask

   task automatic write_vram(input logic [VRAM_AW-1:0] offset, input logic [7:0] data);
      send_beat(FUNC_WRITE, offset, data, 8'($urandom), 8'($urandom));
   endtask

   task automatic render_raw(input logic [7:0] col, input logic [7:0] row);
      send_beat(FUNC_RENDER, VRAM_AW'($urandom), 8'($urandom), col, row);
   endtask

   // loads every byte the pixel will read that has not been written yet, then renders it
   task automatic render_pixel(input logic [7:0] col, input logic [7:0] row);
      logic [7:0]         xp;
      logic [7:0]         yp;
      logic [VRAM_AW-1:0] map_a;
      logic [VRAM_AW-1:0] plane_a;
      if (cfg_mirror.bg_enable && col < SCREEN_WIDTH && row < SCREEN_HEIGHT) begin
         pixel_space(col, row, xp, yp);
         map_a = map_address(xp, yp);
         if (!vram_loaded[map_a]) write_vram(map_a, 8'($urandom));
         plane_a = plane_address(vram_mirror[map_a], yp);
         if (!vram_loaded[plane_a]) write_vram(plane_a, 8'($urandom));
         if (!vram_loaded[plane_a + 1'b1]) write_vram(plane_a + 1'b1, 8'($urandom));
      end
      render_raw(col, row);
   endtask

   task automatic render_with_tile(input logic [7:0] col, input logic [7:0] row,
                                   input logic [7:0] tile);
      logic [7:0] xp;
      logic [7:0] yp;
      pixel_space(col, row, xp, yp);
      write_vram(map_address(xp, yp), tile);
      render_pixel(col, row);
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      // writes leave no result, so let the pipeline empty behind the last pixel
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input csr_index_type idx, input logic [7:0] value);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      case (idx)
         CSR_SCROLL_X:           cfg_mirror.scroll_x           = value;
         CSR_SCROLL_Y:           cfg_mirror.scroll_y           = value;
         CSR_WINDOW_X_RAW:       cfg_mirror.window_x_raw       = value;
         CSR_WINDOW_Y:           cfg_mirror.window_y           = value;
         CSR_BG_ENABLE:          cfg_mirror.bg_enable          = value[0];
         CSR_WINDOW_ENABLE:      cfg_mirror.window_enable      = value[0];
         CSR_TILE_DATA_UNSIGNED: cfg_mirror.tile_data_unsigned = value[0];
         default:                cfg_mirror.map_high           = value[0];
      endcase
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic apply_settings(input cfg_type s);
      wait_idle();
      write_register(CSR_SCROLL_X, s.scroll_x);
      write_register(CSR_SCROLL_Y, s.scroll_y);
      write_register(CSR_WINDOW_X_RAW, s.window_x_raw);
      write_register(CSR_WINDOW_Y, s.window_y);
      write_register(CSR_BG_ENABLE, {7'd0, s.bg_enable});
      write_register(CSR_WINDOW_ENABLE, {7'd0, s.window_enable});
      write_register(CSR_TILE_DATA_UNSIGNED, {7'd0, s.tile_data_unsigned});
      write_register(CSR_MAP_HIGH, {7'd0, s.map_high});
      settings_applied++;
   endtask

   function automatic cfg_type make_settings(input logic [7:0] sx, input logic [7:0] sy,
                                             input logic [7:0] wx, input logic [7:0] wy,
                                             input logic bg, input logic win,
                                             input logic uns, input logic mh);
      cfg_type s;
      s.scroll_x           = sx;
      s.scroll_y           = sy;
      s.window_x_raw       = wx;
      s.window_y           = wy;
      s.bg_enable          = bg;
      s.window_enable      = win;
      s.tile_data_unsigned = uns;
      s.map_high           = mh;
      return s;
   endfunction

   function automatic logic [7:0] random_scroll();
      case ($urandom_range(3))
         0:       return 8'd0;
         1:       return 8'd255;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic cfg_type random_settings();
      logic [7:0] wx;
      logic [7:0] wy;
      case ($urandom_range(4))
         0:       wx = 8'($urandom_range(6));   // left edge clamps at zero
         1:       wx = 8'd7;
         2:       wx = 8'd166;
         3:       wx = 8'd255;
         default: wx = 8'($urandom);
      endcase
      case ($urandom_range(3))
         0:       wy = 8'd0;
         1:       wy = 8'd143;
         2:       wy = 8'd255;
         default: wy = 8'($urandom_range(143));
      endcase
      return make_settings(random_scroll(), random_scroll(), wx, wy,
                           $urandom_range(99) < 85, 1'($urandom), 1'($urandom),
                           1'($urandom));
   endfunction

   task automatic random_item();
      int                 pick;
      int                 k;
      int                 len;
      logic [7:0]         col;
      logic [7:0]         row;
      logic [VRAM_AW-1:0] base;
      pick = $urandom_range(99);
      if (pick < 22) begin
         write_vram(VRAM_AW'($urandom), 8'($urandom));
      end else if (pick < 32) begin
         base = cfg_mirror.map_high ? MAP_HIGH_OFFSET : MAP_LOW_OFFSET;
         write_vram(base + VRAM_AW'($urandom_range(1023)), 8'($urandom));
      end else if (pick < 38) begin
         // load one whole tile, 8 lines of two planes
         base = VRAM_AW'($urandom_range(383) * 16);
         for (k = 0; k < 16; k++) write_vram(base + VRAM_AW'(k), 8'($urandom));
      end else if (pick < 50) begin
         // scan along one line, may run off the right edge
         col = 8'($urandom_range(159));
         row = 8'($urandom_range(143));
         len = $urandom_range(8, 16);
         for (k = 0; k < len; k++) render_pixel(col + 8'(k), row);
      end else if (pick < 58) begin
         if ($urandom_range(1)) render_pixel(8'($urandom_range(160, 255)), 8'($urandom));
         else render_pixel(8'($urandom), 8'($urandom_range(144, 255)));
      end else if (pick < 60) begin
         wait_idle();
      end else begin
         render_pixel(8'($urandom_range(159)), 8'($urandom_range(143)));
      end
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_reset_and_extremes();
      // registers come up cleared, so background is off and every pixel is white
      render_raw(8'd0, 8'd0);
      render_raw(8'd159, 8'd143);
      render_raw(8'd160, 8'd0);
      render_raw(8'd0, 8'd144);
      render_raw(8'd255, 8'd255);
      write_vram(VRAM_AW'(0), 8'h00);
      write_vram(VRAM_AW'(VRAM_BYTES - 1), 8'hFF);
   endtask

   task automatic test_tile_addressing();
      apply_settings(make_settings(8'd0, 8'd0, 8'd7, 8'd0, 1'b1, 1'b0, 1'b1, 1'b0));
      render_with_tile(8'd0, 8'd0, 8'h00);
      render_with_tile(8'd159, 8'd143, 8'hFF);
      // signed numbers: 0x80 is the lowest tile, 0x7F the highest
      apply_settings(make_settings(8'd255, 8'd255, 8'd7, 8'd0, 1'b1, 1'b0, 1'b0, 1'b1));
      render_with_tile(8'd0, 8'd0, 8'h80);
      render_with_tile(8'd159, 8'd143, 8'h7F);
   endtask

   task automatic test_window_edges();
      // raw x below seven clamps the left edge to column zero
      apply_settings(make_settings(8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 1'b1, 1'b0, 1'b1));
      render_pixel(8'd0, 8'd0);
      apply_settings(make_settings(8'd13, 8'd200, 8'd166, 8'd143, 1'b1, 1'b1, 1'b1, 1'b0));
      render_pixel(8'd158, 8'd143);
      render_pixel(8'd159, 8'd143);
      render_pixel(8'd159, 8'd142);
   endtask

   task automatic test_random_traffic();
      int stop_at;
      int phase_end;
      stop_at = beats_sent + RANDOM_BEATS;
      while (beats_sent < stop_at) begin
         apply_settings(random_settings());
         phase_end = beats_sent + PHASE_BEATS;
         while (beats_sent < phase_end) random_item();
      end
   endtask

   task automatic test_output_stall();
      int n;
      apply_settings(make_settings(8'd0, 8'd0, 8'd7, 8'd0, 1'b1, 1'b0, 1'b1, 1'b0));
      hold_request = HOLD_CYCLES;
      for (n = 0; n < 60; n++) render_pixel(8'(n), 8'd10);
      wait_idle();
   endtask

   task automatic test_full_rate();
      int stop_at;
      cfg_type s;
      s = random_settings();
      s.bg_enable = 1'b1;
      apply_settings(s);
      steady_flow = 1'b1;
      stop_at = beats_sent + 200;
      while (beats_sent < stop_at) random_item();
      wait_idle();
      steady_flow = 1'b0;
   endtask

   // rewrite the bytes a pixel reads and render it right behind the writes
   task automatic test_write_then_read();
      int                 n;
      logic [7:0]         col;
      logic [7:0]         row;
      logic [7:0]         xp;
      logic [7:0]         yp;
      logic [VRAM_AW-1:0] map_a;
      logic [VRAM_AW-1:0] plane_a;
      cfg_type            s;
      s = random_settings();
      s.bg_enable = 1'b1;
      apply_settings(s);
      for (n = 0; n < 30; n++) begin
         col = 8'($urandom_range(159));
         row = 8'($urandom_range(143));
         render_pixel(col, row);
         pixel_space(col, row, xp, yp);
         map_a = map_address(xp, yp);
         write_vram(map_a, 8'($urandom));
         render_pixel(col, row);
         plane_a = plane_address(vram_mirror[map_a], yp);
         write_vram(plane_a, 8'($urandom));
         write_vram(plane_a + 1'b1, 8'($urandom));
         render_raw(col, row);
      end
   endtask

   // ---------------------------------------------------------------- response side

   initial begin : rsp_receiver
      int hold_left;
      hold_left     = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= steady_flow || ($urandom_range(99) >= 36);
         end
      end
   end

   always @(posedge clock) begin : pixel_check
      pixel_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_pixels.size() == 0) begin
            report_error($sformatf("pixel at column %0d row %0d with none pending",
                                   rsp_bus.out_column, rsp_bus.out_row));
         end else begin
            want = pending_pixels.pop_front();
            pixels_checked++;
            if (rsp_bus.out_column !== want.column)
               report_error($sformatf("out_column got %0d expected %0d",
                                      rsp_bus.out_column, want.column));
            if (rsp_bus.out_row !== want.row)
               report_error($sformatf("out_row got %0d expected %0d",
                                      rsp_bus.out_row, want.row));
            if (rsp_bus.color_index !== want.color_index)
               report_error($sformatf("color_index at (%0d,%0d) got %0d expected %0d",
                                      want.column, want.row, rsp_bus.color_index,
                                      want.color_index));
            if (rsp_bus.shade !== want.shade)
               report_error($sformatf("shade at (%0d,%0d) got %h expected %h",
                                      want.column, want.row, rsp_bus.shade, want.shade));
         end
      end
   end

   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
             (csr_bus.valid && csr_bus.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("[%0t] timeout: no beat on any channel for %0d cycles, %0d pixels pending",
               $time, STALL_LIMIT, pending_pixels.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // ---------------------------------------------------------------- sequence

   initial begin : stimulus
      req_bus.valid       = 1'b0;
      req_bus.func        = FUNC_WRITE;
      req_bus.vram_offset = '0;
      req_bus.vram_byte   = 8'd0;
      req_bus.column      = 8'd0;
      req_bus.row         = 8'd0;
      csr_bus.valid       = 1'b0;
      csr_bus.index       = CSR_SCROLL_X;
      csr_bus.data        = 8'd0;
      reset               = 1'b1;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_and_extremes();
      test_tile_addressing();
      test_window_edges();
      test_random_traffic();
      test_output_stall();
      test_full_rate();
      test_write_then_read();
      wait_idle();

      $display("summary: %0d beats sent (%0d memory writes, %0d pixel requests), %0d pixels checked",
               beats_sent, writes_sent, renders_sent, pixels_checked);
      $display("summary: %0d register settings incl. window, scroll and tile-mode extremes, %0s",
               settings_applied, "output stall and full-rate phases");
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

/* sim.f */
sv/tbpr_pkg.sv
sv/tbpr_if.sv
sv/tbpr_csr.sv
sv/tbpr_coord.sv
sv/tbpr_vram.sv
sv/tile_background_pixel_render_top.sv
dv/tile_background_pixel_render_top_tb.sv
